[hw/rtl/bvt_pkg.sv]
// shared widths, register indexes and fixed-point helpers for the bounding volume transform
package bvt_pkg;

    localparam int COORD_W   = 20;
    localparam int ENT_W     = 16;
    localparam int VEC_W     = 60;
    localparam int ROW_W     = 48;
    localparam int RAD_W     = 20;
    localparam int CUT_W     = 16;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_W    = 328;
    localparam int USER_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd6;

    localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h1000_0000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ENT_W-1:0]   ent_t;

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               ov;
    } sat_t;

    // 16-bit signed entry c of a packed row (also used for axis components)
    function automatic ent_t row_ent(input logic [ROW_W-1:0] row, input int unsigned c);
        return row[16*c +: 16];
    endfunction

    // 20-bit signed component i of a packed vector
    function automatic coord_t vec_comp(input logic [VEC_W-1:0] v, input int unsigned i);
        return v[20*i +: 20];
    endfunction

    function automatic sat_t sat20(input logic signed [40:0] v);
        sat_t r;
        if (v > 41'sd524287)
        begin
            r.val = 20'h7FFFF;
            r.ov  = 1'b1;
        end
        else if (v < -41'sd524288)
        begin
            r.val = 20'h80000;
            r.ov  = 1'b1;
        end
        else
        begin
            r.val = v[19:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

endpackage

[hw/rtl/bvt_delay.sv]
// delay line with per-stage load enables, keeps side data aligned with the pipeline
module bvt_delay #(
    parameter int W = 8,
    parameter int N = 2
) (
    input  logic         clk,
    input  logic [N-1:0] en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [N];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sr_reg[0] <= d;
        end
        for (int k = 1; k < N; k++)
        begin
            if (en[k])
            begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule

[hw/rtl/bvt_isqrt.sv]
// pipelined digit-by-digit integer square root, floor result
module bvt_isqrt #(
    parameter int W     = 64,
    parameter int STEPS = 2,
    localparam int RW   = W / 2,
    localparam int NS   = RW / STEPS
) (
    input  logic          clk,
    input  logic [NS-1:0] en,
    input  logic [W-1:0]  rad,
    output logic [RW-1:0] root
);

    logic [W-1:0]  rad_s    [NS];
    logic [RW:0]   rem_s    [NS];
    logic [RW-1:0] root_s   [NS];
    logic [W-1:0]  rad_reg  [NS-1];
    logic [RW:0]   rem_reg  [NS];
    logic [RW-1:0] root_reg [NS];

    assign rad_s[0]  = rad;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [W-1:0]  rd_w;
        logic [RW:0]   rm_w;
        logic [RW-1:0] rt_w;

        always_comb
        begin
            logic [RW+2:0] cand;
            logic [RW+2:0] trial;
            rd_w = rad_s[k];
            rm_w = rem_s[k];
            rt_w = root_s[k];
            for (int s = 0; s < STEPS; s++)
            begin
                cand  = {rm_w, rd_w[W-1:W-2]};
                trial = {1'b0, rt_w, 2'b01};
                if (cand >= trial)
                begin
                    rm_w = (RW+1)'(cand - trial);
                    rt_w = {rt_w[RW-2:0], 1'b1};
                end
                else
                begin
                    rm_w = cand[RW:0];
                    rt_w = {rt_w[RW-2:0], 1'b0};
                end
                rd_w = {rd_w[W-3:0], 2'b00};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rm_w;
                root_reg[k] <= rt_w;
            end
        end

        if (k < NS - 1)
        begin : g_link
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rad_reg[k] <= rd_w;
                end
            end
            assign rad_s[k+1]  = rad_reg[k];
            assign rem_s[k+1]  = rem_reg[k];
            assign root_s[k+1] = root_reg[k];
        end
    end

    assign root = root_reg[NS-1];

endmodule

[hw/rtl/bvt_div.sv]
// pipelined restoring divider for quotients known to fit in QW bits
module bvt_div #(
    parameter int VW    = 32,
    parameter int QW    = 16,
    parameter int STEPS = 2,
    localparam int NS   = QW / STEPS
) (
    input  logic             clk,
    input  logic [NS-1:0]    en,
    input  logic [VW+QW-1:0] num,
    input  logic [VW-1:0]    dvsr,
    output logic [QW-1:0]    quo
);

    logic [VW-1:0] pr_s   [NS];
    logic [QW-1:0] lo_s   [NS];
    logic [VW-1:0] dv_s   [NS];
    logic [QW-1:0] q_s    [NS];
    logic [VW-1:0] pr_reg [NS-1];
    logic [QW-1:0] lo_reg [NS-1];
    logic [VW-1:0] dv_reg [NS-1];
    logic [QW-1:0] q_reg  [NS];

    // upper part of the dividend is already below the divisor
    assign pr_s[0] = num[VW+QW-1:QW];
    assign lo_s[0] = num[QW-1:0];
    assign dv_s[0] = dvsr;
    assign q_s[0]  = '0;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [VW-1:0] pr_w;
        logic [QW-1:0] lo_w;
        logic [QW-1:0] q_w;

        always_comb
        begin
            logic [VW:0] t;
            pr_w = pr_s[k];
            lo_w = lo_s[k];
            q_w  = q_s[k];
            for (int s = 0; s < STEPS; s++)
            begin
                t = {pr_w, lo_w[QW-1]};
                if (t >= {1'b0, dv_s[k]})
                begin
                    pr_w = VW'(t - {1'b0, dv_s[k]});
                    q_w  = {q_w[QW-2:0], 1'b1};
                end
                else
                begin
                    pr_w = t[VW-1:0];
                    q_w  = {q_w[QW-2:0], 1'b0};
                end
                lo_w = {lo_w[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                q_reg[k] <= q_w;
            end
        end

        if (k < NS - 1)
        begin : g_link
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    pr_reg[k] <= pr_w;
                    lo_reg[k] <= lo_w;
                    dv_reg[k] <= dv_s[k];
                end
            end
            assign pr_s[k+1] = pr_reg[k];
            assign lo_s[k+1] = lo_reg[k];
            assign dv_s[k+1] = dv_reg[k];
            assign q_s[k+1]  = q_reg[k];
        end
    end

    assign quo = q_reg[NS-1];

endmodule

[hw/rtl/bvt_affine.sv]
// four-stage affine datapath: sphere centre, cone apex and box corners
module bvt_affine
    import bvt_pkg::*;
(
    input  logic                       clk,
    input  logic [3:0]                 en,
    input  logic [2:0][ROW_W-1:0]      lin_rows,
    input  logic [VEC_W-1:0]           trans,
    input  logic [VEC_W-1:0]           center,
    input  logic [VEC_W-1:0]           apex,
    input  logic [VEC_W-1:0]           box_min,
    input  logic [VEC_W-1:0]           box_max,
    output logic [VEC_W-1:0]           center_w,
    output logic [VEC_W-1:0]           apex_w,
    output logic [VEC_W-1:0]           bmin_w,
    output logic [VEC_W-1:0]           bmax_w,
    output logic                       ov
);

    logic signed [35:0] pc_reg   [3][3];
    logic signed [35:0] pa_reg   [3][3];
    logic signed [20:0] s_reg    [3];
    logic signed [20:0] d_reg    [3];
    logic signed [37:0] accc_reg [3];
    logic signed [37:0] acca_reg [3];
    logic signed [36:0] mc_reg   [3][3];
    logic signed [37:0] me_reg   [3][3];
    logic [VEC_W-1:0]   cw_reg;
    logic [VEC_W-1:0]   aw_reg;
    logic               pov_reg;
    logic signed [39:0] c_reg    [3];
    logic signed [39:0] e_reg    [3];
    logic [VEC_W-1:0]   cw2_reg;
    logic [VEC_W-1:0]   aw2_reg;
    logic [VEC_W-1:0]   bmin_reg;
    logic [VEC_W-1:0]   bmax_reg;
    logic               ov_reg;

    sat_t psc  [3];
    sat_t psa  [3];
    sat_t pmin [3];
    sat_t pmax [3];
    logic pov_next;
    logic ov_next;

    function automatic logic signed [16:0] abs_ent(input ent_t m);
        return m[15] ? -17'(m) : 17'(m);
    endfunction

    // stage 0: point products, box sum and difference
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pc_reg[i][j] <= 36'(row_ent(lin_rows[i], j)) * 36'(vec_comp(center, j));
                    pa_reg[i][j] <= 36'(row_ent(lin_rows[i], j)) * 36'(vec_comp(apex, j));
                end
                s_reg[i] <= 21'(vec_comp(box_max, i)) + 21'(vec_comp(box_min, i));
                d_reg[i] <= 21'(vec_comp(box_max, i)) - 21'(vec_comp(box_min, i));
            end
        end
    end

    // stage 1: point sums with translation, box products
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                accc_reg[i] <= (38'(vec_comp(trans, i)) <<< 12) + 38'(pc_reg[i][0])
                             + 38'(pc_reg[i][1]) + 38'(pc_reg[i][2]);
                acca_reg[i] <= (38'(vec_comp(trans, i)) <<< 12) + 38'(pa_reg[i][0])
                             + 38'(pa_reg[i][1]) + 38'(pa_reg[i][2]);
                for (int j = 0; j < 3; j++)
                begin
                    mc_reg[i][j] <= 37'(row_ent(lin_rows[i], j)) * 37'(s_reg[j]);
                    me_reg[i][j] <= 38'(abs_ent(row_ent(lin_rows[i], j))) * 38'(d_reg[j]);
                end
            end
        end
    end

    always_comb
    begin
        pov_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            psc[i]   = sat20(41'((accc_reg[i] + 38'sd2048) >>> 12));
            psa[i]   = sat20(41'((acca_reg[i] + 38'sd2048) >>> 12));
            pov_next = pov_next | psc[i].ov | psa[i].ov;
        end
    end

    // stage 2: point round and clamp, box centre and extent sums (scaled by 2^13)
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                cw_reg[20*i +: 20] <= psc[i].val;
                aw_reg[20*i +: 20] <= psa[i].val;
                c_reg[i] <= (40'(vec_comp(trans, i)) <<< 13) + 40'(mc_reg[i][0])
                          + 40'(mc_reg[i][1]) + 40'(mc_reg[i][2]);
                e_reg[i] <= 40'(me_reg[i][0]) + 40'(me_reg[i][1]) + 40'(me_reg[i][2]);
            end
            pov_reg <= pov_next;
        end
    end

    always_comb
    begin
        ov_next = pov_reg;
        for (int i = 0; i < 3; i++)
        begin
            pmin[i] = sat20(((41'(c_reg[i]) - 41'(e_reg[i])) + 41'sd4096) >>> 13);
            pmax[i] = sat20(((41'(c_reg[i]) + 41'(e_reg[i])) + 41'sd4096) >>> 13);
            ov_next = ov_next | pmin[i].ov | pmax[i].ov;
        end
    end

    // stage 3: box corners round and clamp
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                bmin_reg[20*i +: 20] <= pmin[i].val;
                bmax_reg[20*i +: 20] <= pmax[i].val;
            end
            cw2_reg <= cw_reg;
            aw2_reg <= aw_reg;
            ov_reg  <= ov_next;
        end
    end

    assign center_w = cw2_reg;
    assign apex_w   = aw2_reg;
    assign bmin_w   = bmin_reg;
    assign bmax_w   = bmax_reg;
    assign ov       = ov_reg;

endmodule

[hw/rtl/bounding_volume_transform.sv]
// throughput: one word per cycle while the output is ready; the 64-bit square root and the axis divide set the depth
// each stage holds while its successor is full and stalled, so bubbles are squeezed out under back-pressure
// reset clears all valid bits and loads identity matrices and zero translation
// the column-length unit runs freely and follows register writes to the linear part
module bounding_volume_transform
    import bvt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // center_in, radius_in, box_min_in, box_max_in, apex_in, axis_in, cutoff_in, zero pad
    input  logic [DATA_W-1:0]    s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // center_out, radius_out, box_min_out, box_max_out, apex_out, axis_out, cutoff_out, zero pad
    output logic [DATA_W-1:0]    m_tdata,
    // overflow, degenerate_axis
    output logic [USER_W-1:0]    m_tuser,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int NST = 30;

    logic [2:0][ROW_W-1:0] lin_reg;
    logic [2:0][ROW_W-1:0] nrm_reg;
    logic [VEC_W-1:0]      trans_reg;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    logic [VEC_W-1:0] center_in, box_min_in, box_max_in, apex_in;
    logic [RAD_W-1:0] radius_in;
    logic [ROW_W-1:0] axis_in;
    logic [CUT_W-1:0] cutoff_in;

    assign center_in  = s_tdata[59:0];
    assign radius_in  = s_tdata[79:60];
    assign box_min_in = s_tdata[139:80];
    assign box_max_in = s_tdata[199:140];
    assign apex_in    = s_tdata[259:200];
    assign axis_in    = s_tdata[307:260];
    assign cutoff_in  = s_tdata[323:308];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg[0] <= ROW_X_RST;
            lin_reg[1] <= ROW_Y_RST;
            lin_reg[2] <= ROW_Z_RST;
            nrm_reg[0] <= ROW_X_RST;
            nrm_reg[1] <= ROW_Y_RST;
            nrm_reg[2] <= ROW_Z_RST;
            trans_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LINEAR_X: lin_reg[0] <= cfg_wdata[ROW_W-1:0];
                REG_LINEAR_Y: lin_reg[1] <= cfg_wdata[ROW_W-1:0];
                REG_LINEAR_Z: lin_reg[2] <= cfg_wdata[ROW_W-1:0];
                REG_TRANS:    trans_reg  <= cfg_wdata;
                REG_NORMAL_X: nrm_reg[0] <= cfg_wdata[ROW_W-1:0];
                REG_NORMAL_Y: nrm_reg[1] <= cfg_wdata[ROW_W-1:0];
                REG_NORMAL_Z: nrm_reg[2] <= cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // per-stage load enables; a stage loads when empty or when its successor moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NST-1];

    // ---------------- column lengths of the linear part, free running ----------------
    function automatic logic [30:0] sq_ent(input ent_t e);
        logic signed [31:0] p;
        p = 32'(e) * 32'(e);
        return p[30:0];
    endfunction

    logic [30:0] csq_reg  [3][3];
    logic [31:0] csum_reg [3];
    logic [15:0] clen     [3];
    logic [15:0] maxs_reg;
    logic [15:0] maxs_next;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                csq_reg[j][i] <= sq_ent(row_ent(lin_reg[i], j));
            end
            csum_reg[j] <= 32'(csq_reg[j][0]) + 32'(csq_reg[j][1]) + 32'(csq_reg[j][2]);
        end
        maxs_reg <= maxs_next;
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_col
        bvt_isqrt #(.W(32), .STEPS(2)) u_col_sqrt (
            .clk  (clk),
            .en   ('1),
            .rad  (csum_reg[j]),
            .root (clen[j])
        );
    end

    always_comb
    begin
        maxs_next = clen[0];
        if (clen[1] > maxs_next)
        begin
            maxs_next = clen[1];
        end
        if (clen[2] > maxs_next)
        begin
            maxs_next = clen[2];
        end
    end

    // ---------------- centre, apex and box: stages 0..3 ----------------
    logic [VEC_W-1:0] center_w, apex_w, bmin_w, bmax_w;
    logic             aff_ov;
    logic [VEC_W*4:0] vol_d;

    bvt_affine u_affine (
        .clk      (clk),
        .en       (en[3:0]),
        .lin_rows (lin_reg),
        .trans    (trans_reg),
        .center   (center_in),
        .apex     (apex_in),
        .box_min  (box_min_in),
        .box_max  (box_max_in),
        .center_w (center_w),
        .apex_w   (apex_w),
        .bmin_w   (bmin_w),
        .bmax_w   (bmax_w),
        .ov       (aff_ov)
    );

    bvt_delay #(.W(VEC_W*4+1), .N(25)) u_vol_dly (
        .clk (clk),
        .en  (en[28:4]),
        .d   ({center_w, apex_w, bmin_w, bmax_w, aff_ov}),
        .q   (vol_d)
    );

    // ---------------- radius: stages 0..28 ----------------
    logic [RAD_W-1:0] rad_d;
    logic [CUT_W-1:0] cut_d;
    logic [35:0]      rprod_reg;
    logic [RAD_W-1:0] rad_reg;
    logic             rov_reg;
    logic [36:0]      rsum;
    logic [24:0]      rround;

    bvt_delay #(.W(RAD_W), .N(27)) u_rad_dly (
        .clk (clk),
        .en  (en[26:0]),
        .d   (radius_in),
        .q   (rad_d)
    );

    bvt_delay #(.W(CUT_W), .N(29)) u_cut_dly (
        .clk (clk),
        .en  (en[28:0]),
        .d   (cutoff_in),
        .q   (cut_d)
    );

    assign rsum   = 37'(rprod_reg) + 37'd2048;
    assign rround = rsum[36:12];

    always_ff @(posedge clk)
    begin
        if (en[27])
        begin
            rprod_reg <= 36'(rad_d) * 36'(maxs_reg);
        end
        if (en[28])
        begin
            if (rround > 25'(20'hFFFFF))
            begin
                rad_reg <= 20'hFFFFF;
                rov_reg <= 1'b1;
            end
            else
            begin
                rad_reg <= rround[RAD_W-1:0];
                rov_reg <= 1'b0;
            end
        end
    end

    // ---------------- cone axis ----------------
    logic signed [31:0]   nprod_reg [3][3];
    logic signed [33:0]   nsum_reg  [3];
    logic [2:0][30:0]     mag_reg;
    logic [2:0]           neg_reg;
    logic                 deg_reg;
    logic [61:0]          nsq_reg   [3];
    logic [63:0]          ss_reg;

    logic signed [33:0]   nh        [3];
    logic [2:0][30:0]     mag_next;
    logic [2:0]           neg_next;
    logic                 deg_next;
    logic                 big;

    always_comb
    begin
        big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (nsum_reg[i] >= 34'sd2147483648 || nsum_reg[i] <= -34'sd2147483648)
            begin
                big = 1'b1;
            end
        end
        deg_next = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            // one halving always brings every component below 2^31
            nh[i]       = big ? (nsum_reg[i] >>> 1) : nsum_reg[i];
            neg_next[i] = nh[i][33];
            mag_next[i] = nh[i][33] ? 31'(-nh[i]) : nh[i][30:0];
            if (nh[i] != 34'sd0)
            begin
                deg_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    nprod_reg[i][j] <= 32'(row_ent(nrm_reg[i], j)) * 32'(row_ent(axis_in, j));
                end
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                nsum_reg[i] <= 34'(nprod_reg[i][0]) + 34'(nprod_reg[i][1])
                             + 34'(nprod_reg[i][2]);
            end
        end
        if (en[2])
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            deg_reg <= deg_next;
        end
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                nsq_reg[i] <= 62'(mag_reg[i]) * 62'(mag_reg[i]);
            end
        end
        if (en[4])
        begin
            ss_reg <= 64'(nsq_reg[0]) + 64'(nsq_reg[1]) + 64'(nsq_reg[2]);
        end
    end

    logic [31:0]      alen;
    logic [2:0][30:0] mag_d;
    logic [2:0]       neg_d;
    logic             deg_d;
    logic [2:0]       neg_d2;
    logic             deg_d2;
    logic [47:0]      num    [3];
    logic [15:0]      quo    [3];

    bvt_isqrt #(.W(64), .STEPS(2)) u_axis_sqrt (
        .clk  (clk),
        .en   (en[20:5]),
        .rad  (ss_reg),
        .root (alen)
    );

    bvt_delay #(.W(97), .N(18)) u_mag_dly (
        .clk (clk),
        .en  (en[20:3]),
        .d   ({mag_reg, neg_reg, deg_reg}),
        .q   ({mag_d, neg_d, deg_d})
    );

    bvt_delay #(.W(4), .N(8)) u_sgn_dly (
        .clk (clk),
        .en  (en[28:21]),
        .d   ({neg_d, deg_d}),
        .q   ({neg_d2, deg_d2})
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_norm
        // |n| * 2^14 + len/2, quotient never above 2^14
        assign num[i] = 48'({mag_d[i], 14'b0}) + 48'(alen >> 1);

        bvt_div #(.VW(32), .QW(16), .STEPS(2)) u_div (
            .clk  (clk),
            .en   (en[28:21]),
            .num  (num[i]),
            .dvsr (alen),
            .quo  (quo[i])
        );
    end

    // ---------------- output word ----------------
    logic [ROW_W-1:0]  axis_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [USER_W-1:0] out_user_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (deg_d2)
            begin
                axis_next[16*i +: 16] = '0;
            end
            else if (neg_d2[i])
            begin
                axis_next[16*i +: 16] = -quo[i];
            end
            else
            begin
                axis_next[16*i +: 16] = quo[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            out_data_reg <= {4'b0, cut_d, axis_next, vol_d[VEC_W*3:VEC_W*2+1],
                             vol_d[VEC_W:1], vol_d[VEC_W*2:VEC_W+1], rad_reg,
                             vol_d[VEC_W*4:VEC_W*3+1]};
            out_user_reg <= {deg_d2, vol_d[0] | rov_reg};
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

[bench/tb_top.sv]
// self-checking bench for the bounding volume transform: predictor, drivers and monitor
`timescale 1ns / 100ps

import bvt_pkg::*;

typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [USER_W-1:0] user;
} volume_word_t;

// keeps a copy of the transform registers and the queue of predicted world volumes
class volume_board;
    logic [ROW_W-1:0] lin_row[3];
    logic [ROW_W-1:0] nrm_row[3];
    logic [VEC_W-1:0] trans;
    volume_word_t     world_q[$];
    int               mismatches;
    int               results_seen;
    int               overflow_seen;
    int               degen_seen;

    function new();
        lin_row[0] = ROW_X_RST;
        lin_row[1] = ROW_Y_RST;
        lin_row[2] = ROW_Z_RST;
        nrm_row    = lin_row;
        trans      = '0;
        mismatches = 0;
        results_seen = 0;
        overflow_seen = 0;
        degen_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_LINEAR_X: lin_row[0] = val[ROW_W-1:0];
            REG_LINEAR_Y: lin_row[1] = val[ROW_W-1:0];
            REG_LINEAR_Z: lin_row[2] = val[ROW_W-1:0];
            REG_TRANS:    trans      = val;
            REG_NORMAL_X: nrm_row[0] = val[ROW_W-1:0];
            REG_NORMAL_Y: nrm_row[1] = val[ROW_W-1:0];
            REG_NORMAL_Z: nrm_row[2] = val[ROW_W-1:0];
            default: ;
        endcase
    endfunction

    static function longint lin_ent(logic [ROW_W-1:0] row, int c);
        ent_t e;
        e = row[16*c +: 16];
        return longint'(e);
    endfunction

    static function longint coord(logic [VEC_W-1:0] v, int i);
        coord_t x;
        x = v[20*i +: 20];
        return longint'(x);
    endfunction

    static function longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    static function logic [COORD_W-1:0] clamp20(longint v, inout bit ov);
        if (v > 524287)
        begin
            v = 524287;
            ov = 1;
        end
        if (v < -524288)
        begin
            v = -524288;
            ov = 1;
        end
        return v[19:0];
    endfunction

    function logic [VEC_W-1:0] map_point(logic [VEC_W-1:0] p, inout bit ov);
        logic [VEC_W-1:0] r;
        longint acc;
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            acc = coord(trans, i) * 4096;
            for (int j = 0; j < 3; j++)
                acc += lin_ent(lin_row[i], j) * coord(p, j);
            r[20*i +: 20] = clamp20((acc + 2048) >>> 12, ov);
        end
        return r;
    endfunction

    function void note_input(logic [DATA_W-1:0] d);
        volume_word_t w;
        bit ov;
        longint unsigned max_len;
        longint unsigned ss;
        longint unsigned len;
        longint unsigned rad;
        longint unsigned mag;
        longint unsigned q;
        longint c;
        longint e;
        longint m;
        longint lo;
        longint hi;
        longint n[3];
        bit big;
        ent_t ax;
        w = '0;
        ov = 0;
        w.data[59:0] = map_point(d[59:0], ov);

        max_len = 0;
        for (int j = 0; j < 3; j++)
        begin
            ss = 0;
            for (int i = 0; i < 3; i++)
                ss += lin_ent(lin_row[i], j) * lin_ent(lin_row[i], j);
            len = int_root(ss);
            if (len > max_len)
                max_len = len;
        end
        rad = (longint'(d[79:60]) * max_len + 2048) >> 12;
        if (rad > 64'hFFFFF)
        begin
            rad = 64'hFFFFF;
            ov = 1;
        end
        w.data[79:60] = rad[19:0];

        for (int i = 0; i < 3; i++)
        begin
            c = coord(trans, i) * 8192;
            e = 0;
            for (int j = 0; j < 3; j++)
            begin
                lo = coord(d[139:80], j);
                hi = coord(d[199:140], j);
                m = lin_ent(lin_row[i], j);
                c += m * (hi + lo);
                e += (m < 0 ? -m : m) * (hi - lo);
            end
            w.data[80 + 20*i +: 20] = clamp20((c - e + 4096) >>> 13, ov);
            w.data[140 + 20*i +: 20] = clamp20((c + e + 4096) >>> 13, ov);
        end

        w.data[259:200] = map_point(d[259:200], ov);

        for (int i = 0; i < 3; i++)
        begin
            n[i] = 0;
            for (int j = 0; j < 3; j++)
            begin
                ax = d[260 + 16*j +: 16];
                n[i] += lin_ent(nrm_row[i], j) * longint'(ax);
            end
        end
        // prescale until every component fits in 32 bits
        do
        begin
            big = 0;
            for (int i = 0; i < 3; i++)
                if (n[i] >= (64'sd1 <<< 31) || n[i] <= -(64'sd1 <<< 31))
                    big = 1;
            if (big)
                for (int i = 0; i < 3; i++)
                    n[i] = n[i] >>> 1;
        end
        while (big);
        ss = 0;
        for (int i = 0; i < 3; i++)
            ss += n[i] * n[i];
        len = int_root(ss);
        if (len == 0)
            w.user[1] = 1'b1;
        else
            for (int i = 0; i < 3; i++)
            begin
                mag = n[i] < 0 ? -n[i] : n[i];
                q = (mag * 16384 + len / 2) / len;
                if (n[i] < 0)
                    q = -q;
                w.data[260 + 16*i +: 16] = q[15:0];
            end
        w.data[323:308] = d[323:308];
        w.user[0] = ov;
        world_q.push_back(w);
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
        end
    endfunction

    function void check_result(logic [DATA_W-1:0] d, logic [USER_W-1:0] u);
        volume_word_t x;
        results_seen++;
        if (world_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected word, got %h / %h", $time, d, u);
            return;
        end
        x = world_q.pop_front();
        if (x.user[0])
            overflow_seen++;
        if (x.user[1])
            degen_seen++;
        check_field("center", x.data[59:0], d[59:0]);
        check_field("radius", x.data[79:60], d[79:60]);
        check_field("box_min", x.data[139:80], d[139:80]);
        check_field("box_max", x.data[199:140], d[199:140]);
        check_field("apex", x.data[259:200], d[259:200]);
        check_field("axis", x.data[307:260], d[307:260]);
        check_field("cutoff", x.data[323:308], d[323:308]);
        check_field("pad", x.data[DATA_W-1:324], d[DATA_W-1:324]);
        check_field("overflow", x.user[0], u[0]);
        check_field("degenerate_axis", x.user[1], u[1]);
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 45;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic [USER_W-1:0]    m_tuser;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    volume_board board = new();
    int  cycles = 0;
    int  sent = 0;
    int  settings = 0;
    bit  calm = 0;
    int  stall_left = 0;

    bounding_volume_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // output side: check accepted words, then choose the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_word(logic [DATA_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(d);
        sent++;
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.write_reg(idx, val);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (board.world_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [VEC_W-1:0] vec3(logic [19:0] x, logic [19:0] y, logic [19:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [ROW_W-1:0] row3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [DATA_W-1:0] volume(logic [59:0] ctr, logic [19:0] rad,
                                                 logic [59:0] bmin, logic [59:0] bmax,
                                                 logic [59:0] apex, logic [47:0] axis,
                                                 logic [15:0] cut);
        return {4'b0, cut, axis, apex, bmax, bmin, rad, ctr};
    endfunction

    function automatic logic [19:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 20'($urandom());
            1: return 20'($urandom_range(0, 4000)) - 20'd2000;
            2: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
            default: return 20'($urandom_range(0, 200000)) - 20'd100000;
        endcase
    endfunction

    function automatic logic [15:0] rand_ent(int span);
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 2 * span)) - 16'(span);
    endfunction

    function automatic logic [DATA_W-1:0] rand_volume();
        logic [59:0] lo;
        logic [59:0] hi;
        logic [47:0] axis;
        for (int i = 0; i < 3; i++)
        begin
            lo[20*i +: 20] = rand_coord();
            // mostly well-formed boxes, some inverted
            if ($urandom_range(0, 9) == 0)
                hi[20*i +: 20] = rand_coord();
            else
                hi[20*i +: 20] = lo[20*i +: 20] + 20'($urandom_range(0, 3000));
            axis[16*i +: 16] = 16'($urandom());
        end
        case ($urandom_range(0, 9))
            0: axis = '0;
            1: axis = row3(16'($urandom_range(0, 3)) - 16'd1, 16'h0, 16'h0);
            default: ;
        endcase
        return volume(vec3(rand_coord(), rand_coord(), rand_coord()),
                      $urandom_range(0, 3) == 0 ? 20'($urandom()) : 20'($urandom_range(0, 5000)),
                      lo, hi, vec3(rand_coord(), rand_coord(), rand_coord()),
                      axis, 16'($urandom()));
    endfunction

    task automatic load_setting(logic [ROW_W-1:0] l0, logic [ROW_W-1:0] l1,
                                logic [ROW_W-1:0] l2, logic [VEC_W-1:0] t,
                                logic [ROW_W-1:0] n0, logic [ROW_W-1:0] n1,
                                logic [ROW_W-1:0] n2);
        wait_idle();
        write_reg(REG_LINEAR_X, l0);
        write_reg(REG_LINEAR_Y, l1);
        write_reg(REG_LINEAR_Z, l2);
        write_reg(REG_TRANS, t);
        write_reg(REG_NORMAL_X, n0);
        write_reg(REG_NORMAL_Y, n1);
        write_reg(REG_NORMAL_Z, n2);
        // unused index must be ignored
        write_reg(REG_UNUSED, {CFG_W{1'b1}});
        cfg_wr_en <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        settings++;
    endtask

    task automatic random_burst(int count);
        for (int k = 0; k < count; k++)
        begin
            if (k % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_word(rand_volume());
        end
        calm = 0;
    endtask

    function automatic logic [ROW_W-1:0] rand_row(int span);
        return row3(rand_ent(span), rand_ent(span), rand_ent(span));
    endfunction

    function automatic logic [VEC_W-1:0] rand_vec();
        return vec3(rand_coord(), rand_coord(), rand_coord());
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        // directed words under the reset transform
        send_word('0);
        send_word(volume(vec3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF), 20'hFFFFF,
                         vec3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF),
                         vec3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF),
                         vec3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF),
                         row3(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'h7FFF));
        send_word(volume(vec3(20'h80000, 20'h80000, 20'h80000), 20'h00001,
                         vec3(20'h80000, 20'h80000, 20'h80000),
                         vec3(20'h80000, 20'h80000, 20'h80000),
                         vec3(20'h80000, 20'h80000, 20'h80000),
                         row3(16'h8000, 16'h8000, 16'h8000), 16'h8000));
        // widest box, and inverted boxes
        send_word(volume('0, 20'd1024, vec3(20'h80000, 20'h80000, 20'h80000),
                         vec3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF), '0,
                         row3(16'h4000, 16'h0, 16'h0), 16'h0));
        send_word(volume('0, 20'd1024, vec3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF),
                         vec3(20'h80000, 20'h80000, 20'h80000), '0,
                         row3(16'h0, 16'hC000, 16'h0), 16'h1234));
        send_word(volume('0, 20'd0, vec3(20'd500, 20'd7, 20'hFFFFF),
                         vec3(20'd100, 20'hFFF00, 20'hFFFF0), '0,
                         row3(16'h0, 16'h0, 16'h0), 16'hFFFF));
        // axis at the signed extremes and at one, for each component
        for (int i = 0; i < 3; i++)
        begin
            send_word(volume('0, 20'd0, '0, '0, '0, 48'h7FFF << (16 * i), 16'h0));
            send_word(volume('0, 20'd0, '0, '0, '0, 48'h8000 << (16 * i), 16'h0));
            send_word(volume('0, 20'd0, '0, '0, '0, 48'h0001 << (16 * i), 16'h0));
        end
        send_word(volume(vec3(20'd1, 20'hFFFFF, 20'd0), 20'd1, '0, '0,
                         vec3(20'hFFFFF, 20'd1, 20'd0), row3(16'h1, 16'h1, 16'h1), 16'h0));
        random_burst(120);

        // moderate random transforms
        load_setting(rand_row(4096), rand_row(4096), rand_row(4096),
                     vec3(20'($urandom_range(0, 20000)) - 20'd10000, 20'd3000, 20'hFF000),
                     rand_row(4096), rand_row(4096), rand_row(4096));
        random_burst(130);

        // largest entries and translation: saturation in many fields
        load_setting(row3(16'h7FFF, 16'h7FFF, 16'h7FFF), row3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     row3(16'h7FFF, 16'h7FFF, 16'h7FFF), vec3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF),
                     row3(16'h8000, 16'h8000, 16'h8000), row3(16'h8000, 16'h8000, 16'h8000),
                     row3(16'h8000, 16'h8000, 16'h8000));
        random_burst(110);

        // most negative entries, zero normal matrix makes every axis degenerate
        load_setting(row3(16'h8000, 16'h8000, 16'h8000), row3(16'h8000, 16'h8000, 16'h8000),
                     row3(16'h8000, 16'h8000, 16'h8000), vec3(20'h80000, 20'h80000, 20'h80000),
                     '0, '0, '0);
        random_burst(90);

        // arbitrary register contents, upper bits included
        load_setting(ROW_W'({$urandom(), $urandom()}), ROW_W'({$urandom(), $urandom()}),
                     ROW_W'({$urandom(), $urandom()}), VEC_W'({$urandom(), $urandom()}),
                     ROW_W'({$urandom(), $urandom()}), ROW_W'({$urandom(), $urandom()}),
                     ROW_W'({$urandom(), $urandom()}));
        random_burst(130);

        // scaled diagonal with a small shear
        load_setting(row3(16'h2000, 16'h0100, 16'h0), row3(16'h0, 16'h0800, 16'hFF00),
                     row3(16'h0, 16'h0, 16'h3000), rand_vec(),
                     row3(16'h0800, 16'h0, 16'h0), row3(16'hFFE0, 16'h2000, 16'h0),
                     row3(16'h0, 16'h0, 16'h0555));
        random_burst(130);

        // back to identity, with translation
        load_setting(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, rand_vec(),
                     ROW_X_RST, ROW_Y_RST, ROW_Z_RST);
        random_burst(100);

        wait_idle();
        $display("%0d words sent under %0d register settings after reset", sent, settings);
        $display("%0d results checked, %0d saturated, %0d degenerate axes",
                 board.results_seen, board.overflow_seen, board.degen_seen);
        if (board.mismatches == 0 && board.world_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[bounding_volume_transform.f]
hw/rtl/bvt_pkg.sv
hw/rtl/bvt_delay.sv
hw/rtl/bvt_isqrt.sv
hw/rtl/bvt_div.sv
hw/rtl/bvt_affine.sv
hw/rtl/bounding_volume_transform.sv
bench/tb_top.sv
